[sv/quartic_sum_hit_verifier_top_defines.svh]
// Assertion macros used by the checker file of the quartic sum hit verifier.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef QUARTIC_SUM_HIT_VERIFIER_TOP_DEFINES_SVH
`define QUARTIC_SUM_HIT_VERIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSHV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qshv same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QSHV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qshv next-cycle check failed");

`endif

[sv/qshv_pkg.sv]
`default_nettype none

package qshv_pkg;

  // Field and datapath widths.
  localparam int XW    = 18;  // x, y and root width
  localparam int TW    = 16;  // t width
  localparam int NW    = 8;   // multiplier register width
  localparam int SQW   = 2 * XW;        // square of an 18-bit value
  localparam int PW    = SQW + XW;      // shared multiplier product width
  localparam int DW    = 4 * XW;        // fourth power width
  localparam int ACC_W = DW + 1;        // sum of two fourth powers
  localparam int BW    = 5;   // root bit index width
  localparam int KW    = 5;   // common power-of-two count in the gcd
  localparam int GIW   = 2;   // gcd pair index width

  // Configuration.
  localparam int          CFG_AW   = 3;
  localparam int          CFG_DW   = 32;
  localparam logic        REG_N    = 1'b0;   // word index of n_multiplier
  localparam logic [NW-1:0] N_RESET = 8'd17;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_LO,
    ST_HI,
    ST_NLO,
    ST_NHI,
    ST_CHECK,
    ST_RCMP,
    ST_FIN,
    ST_GCD,
    ST_DONE
  } state_t;

  // Which operand the fourth-power sequence is working on.
  typedef enum logic [1:0] {
    PH_T,
    PH_X,
    PH_Y,
    PH_ROOT
  } phase_t;

  // Alignment of the product before accumulation.
  typedef enum logic [1:0] {
    SH_0,
    SH_18,
    SH_36
  } shift_t;

  // Gcd pair codes.
  localparam logic [GIW-1:0] GP_XY = 2'd0;
  localparam logic [GIW-1:0] GP_Z  = 2'd1;

endpackage

`default_nettype wire

[sv/quartic_sum_hit_verifier_top.sv]
// Items whose sum is zero or exceeds N*t^4 finish after the range check; the others go on
// to the root search, and those with a hit also run the gcd. One item is taken at a time;
// busy stays high through the result strobe. The time is set by the single 36x18 multiplier,
// reused for every fourth power and each of the 18 root bits, and by the one-step-per-cycle
// binary gcd.
// Reset (rst_n low, synchronous) returns the sequencer to idle and N to 17.
`default_nettype none

module quartic_sum_hit_verifier_top import qshv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Command channel.
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [XW-1:0]     in_x_value,
  input  wire logic [XW-1:0]     in_y_value,
  input  wire logic [TW-1:0]     in_t_value,
  // Result channel.
  output logic                   out_valid,
  output logic [XW-1:0]          out_z_root,
  output logic                   out_hit,
  output logic                   out_primitive_res,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  state_t            state_r, state_nxt;
  phase_t            phase_r;
  logic [NW-1:0]     n_r;
  logic [XW-1:0]     x_r, y_r;
  logic [TW-1:0]     t_r;
  logic [SQW-1:0]    sq_r;
  logic [ACC_W-1:0]  acc_r;
  logic [DW-1:0]     s_r, d_r;
  logic [XW-1:0]     root_r;
  logic [BW-1:0]     bit_r;
  logic              exact_r;
  logic [XW-1:0]     ga_r, gb_r;
  logic [KW-1:0]     k_r;
  logic [GIW-1:0]    gidx_r;
  logic [XW-1:0]     z_r;
  logic              hit_r, prim_r;

  // Configuration register write and read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= N_RESET;
    end else if (psel && penable && pwrite && (paddr[CFG_AW-1] == REG_N)) begin
      n_r <= pwdata[NW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1] == REG_N) ? {{(CFG_DW-NW){1'b0}}, n_r} : '0;

  // Operand for the squaring step.
  logic [XW-1:0] cand;
  logic [XW-1:0] op_val;

  assign cand = root_r | (XW'(1) << bit_r);

  always_comb begin
    case (phase_r)
      PH_T:    op_val = {{(XW-TW){1'b0}}, t_r};
      PH_X:    op_val = x_r;
      PH_Y:    op_val = y_r;
      default: op_val = cand;
    endcase
  end

  // Shared multiplier operand selection.
  logic [SQW-1:0] mul_a;
  logic [XW-1:0]  mul_b;
  shift_t         mul_sh;
  logic           acc_clr;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = SH_0;
    acc_clr = 1'b0;
    case (state_r)
      ST_SQ: begin
        mul_a = {{(SQW-XW){1'b0}}, op_val};
        mul_b = op_val;
      end
      ST_LO: begin
        mul_a   = sq_r;
        mul_b   = sq_r[XW-1:0];
        acc_clr = (phase_r != PH_Y);
      end
      ST_HI: begin
        mul_a  = sq_r;
        mul_b  = sq_r[SQW-1:XW];
        mul_sh = SH_18;
      end
      ST_NLO: begin
        mul_a   = s_r[SQW-1:0];
        mul_b   = {{(XW-NW){1'b0}}, n_r};
        acc_clr = 1'b1;
      end
      ST_NHI: begin
        mul_a  = s_r[DW-1:SQW];
        mul_b  = {{(XW-NW){1'b0}}, n_r};
        mul_sh = SH_36;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Multiply, align and accumulate.
  logic [PW-1:0]    prod;
  logic [ACC_W-1:0] prod_ext, shifted, acc_add;

  assign prod     = PW'(mul_a) * PW'(mul_b);
  assign prod_ext = ACC_W'(prod);

  always_comb begin
    case (mul_sh)
      SH_18:   shifted = prod_ext << XW;
      SH_36:   shifted = prod_ext << SQW;
      default: shifted = prod_ext;
    endcase
  end

  assign acc_add = (acc_clr ? '0 : acc_r) + shifted;

  // Range check of the sum against N*t^4, and the root candidate compare.
  logic [ACC_W:0] diff;
  logic           sum_bad;
  logic           cand_le, cand_eq;
  logic           hit_cond;

  assign diff     = {2'b00, s_r} - {1'b0, acc_r};
  assign sum_bad  = (acc_r == '0) || diff[ACC_W];
  assign cand_le  = (acc_r <= {1'b0, d_r});
  assign cand_eq  = (acc_r == {1'b0, d_r});
  assign hit_cond = exact_r && (y_r <= root_r);

  // One binary gcd step per cycle.
  logic          g_done;
  logic [XW-1:0] g_val;
  logic [XW-1:0] ga_s, gb_s;
  logic [KW-1:0] k_s;

  assign g_done = (ga_r == '0) || (gb_r == '0);
  assign g_val  = ((gb_r == '0) ? ga_r : gb_r) << k_r;

  always_comb begin
    ga_s = ga_r;
    gb_s = gb_r;
    k_s  = k_r;
    if (!ga_r[0] && !gb_r[0]) begin
      ga_s = ga_r >> 1;
      gb_s = gb_r >> 1;
      k_s  = k_r + KW'(1);
    end else if (!ga_r[0]) begin
      ga_s = ga_r >> 1;
    end else if (!gb_r[0]) begin
      gb_s = gb_r >> 1;
    end else if (ga_r >= gb_r) begin
      ga_s = (ga_r - gb_r) >> 1;
    end else begin
      gb_s = (gb_r - ga_r) >> 1;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_LO;
      ST_LO:    state_nxt = ST_HI;
      ST_HI: begin
        case (phase_r)
          PH_T:    state_nxt = ST_NLO;
          PH_X:    state_nxt = ST_SQ;
          PH_Y:    state_nxt = ST_CHECK;
          default: state_nxt = ST_RCMP;
        endcase
      end
      ST_NLO:   state_nxt = ST_NHI;
      ST_NHI:   state_nxt = ST_SQ;
      ST_CHECK: state_nxt = sum_bad ? ST_DONE : ST_SQ;
      ST_RCMP:  state_nxt = (bit_r == '0) ? ST_FIN : ST_SQ;
      ST_FIN:   state_nxt = hit_cond ? ST_GCD : ST_DONE;
      ST_GCD:   if (g_done && (gidx_r != GP_XY) && (gidx_r != GP_Z)) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers, loaded under the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_r     <= in_x_value;
          y_r     <= in_y_value;
          t_r     <= in_t_value;
          phase_r <= PH_T;
        end
      end
      ST_SQ: begin
        sq_r <= prod[SQW-1:0];
      end
      ST_LO: begin
        acc_r <= acc_add;
      end
      ST_HI: begin
        acc_r <= acc_add;
        if (phase_r == PH_T) begin
          s_r <= acc_add[DW-1:0];
        end else if (phase_r == PH_X) begin
          phase_r <= PH_Y;
        end
      end
      ST_NLO: begin
        acc_r <= acc_add;
      end
      ST_NHI: begin
        s_r     <= acc_add[DW-1:0];
        phase_r <= PH_X;
      end
      ST_CHECK: begin
        if (sum_bad) begin
          z_r    <= '0;
          hit_r  <= 1'b0;
          prim_r <= 1'b0;
        end else begin
          d_r     <= diff[DW-1:0];
          root_r  <= '0;
          bit_r   <= BW'(XW - 1);
          exact_r <= (diff == '0);
          phase_r <= PH_ROOT;
        end
      end
      ST_RCMP: begin
        // Keep the candidate bit when its fourth power does not exceed the difference.
        if (cand_le) begin
          root_r  <= cand;
          exact_r <= cand_eq;
        end
        if (bit_r != '0) begin
          bit_r <= bit_r - BW'(1);
        end
      end
      ST_FIN: begin
        z_r    <= root_r;
        hit_r  <= hit_cond;
        prim_r <= 1'b0;
        ga_r   <= x_r;
        gb_r   <= y_r;
        k_r    <= '0;
        gidx_r <= GP_XY;
      end
      ST_GCD: begin
        if (g_done) begin
          // Fold the finished gcd into the next pair.
          k_r    <= '0;
          gidx_r <= gidx_r + GIW'(1);
          case (gidx_r)
            GP_XY: begin
              ga_r <= g_val;
              gb_r <= root_r;
            end
            GP_Z: begin
              ga_r <= g_val;
              gb_r <= {{(XW-TW){1'b0}}, t_r};
            end
            default: begin
              prim_r <= (g_val == XW'(1));
            end
          endcase
        end else begin
          ga_r <= ga_s;
          gb_r <= gb_s;
          k_r  <= k_s;
        end
      end
      default: begin
        sq_r <= sq_r;
      end
    endcase
  end

  // Handshake and result outputs.
  always_comb begin
    busy              = (state_r != ST_IDLE);
    out_valid         = (state_r == ST_DONE);
    out_z_root        = z_r;
    out_hit           = hit_r;
    out_primitive_res = prim_r;
  end

endmodule

`default_nettype wire

[sv/qshv_checker.sv]
`default_nettype none
`include "quartic_sum_hit_verifier_top_defines.svh"

module qshv_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_hit,
  input wire logic out_primitive_res
);

  // The result strobe is shown while the item is still in progress.
  `QSHV_ASSERT_IMP(a_valid_in_busy, out_valid, busy)

  // The strobe lasts one cycle and the block is free right after it.
  `QSHV_ASSERT_NEXT(a_valid_then_free, out_valid, !out_valid && !busy)

  // An accepted item makes the block busy.
  `QSHV_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // A primitive result is always a hit.
  `QSHV_ASSERT_IMP(a_prim_needs_hit, out_valid && out_primitive_res, out_hit)

  // The block only goes free after delivering its result.
  `QSHV_ASSERT_IMP(a_free_after_result, $fell(busy) && $past(rst_n), $past(out_valid))

endmodule

bind quartic_sum_hit_verifier_top qshv_checker u_qshv_checker (.*);

`default_nettype wire

[sim/quartic_hit_checker.sv]
module quartic_hit_checker import qshv_pkg::*; #(
  parameter logic [CFG_AW-1:0] N_ADDR = '0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [XW-1:0]     in_x_value,
  input  wire logic [XW-1:0]     in_y_value,
  input  wire logic [TW-1:0]     in_t_value,
  input  wire logic              out_valid,
  input  wire logic [XW-1:0]     out_z_root,
  input  wire logic              out_hit,
  input  wire logic              out_primitive_res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  input  wire logic              pready,
  output int                     pending,
  output int                     mismatches,
  output int                     results,
  output int                     hits,
  output int                     primitives
);
  timeunit 1ns;
  timeprecision 1ps;

  // Exact integer width; fourth powers stay below 2^73, so nothing wraps.
  localparam int WIDE = 80;

  typedef struct packed {
    logic [XW-1:0] z_root;
    logic          hit;
    logic          primitive_res;
  } root_verdict_t;

  logic [NW-1:0] n_mult;
  root_verdict_t root_verdicts_q[$];
  int            mismatch_tally;
  int            result_tally;
  int            hit_tally;
  int            prim_tally;

  function automatic logic [WIDE-1:0] fourth_power(input logic [XW-1:0] a);
    logic [WIDE-1:0] w;
    w = WIDE'(a);
    return w * w * w * w;
  endfunction

  // Build the root from the top bit down, keeping each bit whose power still fits.
  function automatic logic [XW-1:0] floor_root4(input logic [WIDE-1:0] d);
    logic [XW-1:0] r;
    logic [XW-1:0] c;
    r = '0;
    for (int b = XW - 1; b >= 0; b--) begin
      c = r;
      c[b] = 1'b1;
      if (fourth_power(c) <= d) r = c;
    end
    return r;
  endfunction

  function automatic logic [XW-1:0] euclid(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [XW-1:0] m;
    while (b != 0) begin
      m = a % b;
      a = b;
      b = m;
    end
    return a;
  endfunction

  // Expected result of one candidate under the current multiplier.
  function automatic root_verdict_t judge_candidate(input logic [XW-1:0] x,
                                                    input logic [XW-1:0] y,
                                                    input logic [TW-1:0] t);
    root_verdict_t rv;
    logic [WIDE-1:0] s;
    logic [WIDE-1:0] v;
    logic [WIDE-1:0] d;
    rv = '0;
    s = WIDE'(n_mult) * fourth_power(XW'(t));
    v = fourth_power(x) + fourth_power(y);
    if (v != 0 && v <= s) begin
      d = s - v;
      rv.z_root = floor_root4(d);
      if (fourth_power(rv.z_root) == d && y <= rv.z_root) begin
        rv.hit = 1'b1;
        rv.primitive_res = (euclid(euclid(x, y), euclid(rv.z_root, XW'(t))) == 1);
      end
    end
    return rv;
  endfunction

  always @(posedge clk) begin
    root_verdict_t want;
    if (!rst_n) begin
      n_mult = N_RESET;
      root_verdicts_q.delete();
    end else begin
      // Results are retired before new items, in case both land on one edge.
      if (out_valid === 1'b1) begin
        result_tally++;
        if (out_hit === 1'b1) hit_tally++;
        if (out_primitive_res === 1'b1) prim_tally++;
        if (root_verdicts_q.size() == 0) begin
          mismatch_tally++;
          if (mismatch_tally <= 10)
            $display("%t: result with no item pending: z=%0d hit=%b primitive=%b", $realtime,
                     out_z_root, out_hit, out_primitive_res);
        end else begin
          want = root_verdicts_q.pop_front();
          if (out_z_root !== want.z_root || out_hit !== want.hit ||
              out_primitive_res !== want.primitive_res) begin
            mismatch_tally++;
            if (mismatch_tally <= 10)
              $display({"%t: result %0d: expected z=%0d hit=%b primitive=%b, ",
                        "got z=%0d hit=%b primitive=%b"},
                       $realtime, result_tally, want.z_root, want.hit, want.primitive_res,
                       out_z_root, out_hit, out_primitive_res);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        root_verdicts_q.insert(root_verdicts_q.size(),
                               judge_candidate(in_x_value, in_y_value, in_t_value));
      // Only writes to the multiplier address are tracked; other writes fall away.
      if (psel && penable && pwrite && pready && paddr == N_ADDR)
        n_mult = pwdata[NW-1:0];
    end
    pending    <= root_verdicts_q.size();
    mismatches <= mismatch_tally;
    results    <= result_tally;
    hits       <= hit_tally;
    primitives <= prim_tally;
  end

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qshv_pkg::*;

  localparam logic [CFG_AW-1:0] ADDR_N_MULT = {REG_N, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SPARE  = {~REG_N, 2'b00};
  localparam logic [XW-1:0]     X_MAX       = '1;
  localparam logic [TW-1:0]     T_MAX       = '1;
  localparam int                PHASES      = 14;
  localparam int                PHASE_ITEMS = 100;

  // Multipliers of the random phases; a negative entry means a random one.
  localparam int PHASE_N [PHASES] = '{3, 98, 17, 255, 33, 163, 1, -1, 18, 0, 97, -1, 48, 82};

  typedef struct {
    int a;
    int b;
    int c;
  } quartic_triple_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [XW-1:0]     in_x_value;
  logic [XW-1:0]     in_y_value;
  logic [TW-1:0]     in_t_value;
  logic              out_valid;
  logic [XW-1:0]     out_z_root;
  logic              out_hit;
  logic              out_primitive_res;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int pending;
  int mismatches;
  int results;
  int hits;
  int primitives;

  int              candidates_sent;
  int              settings_used;
  quartic_triple_t triples_q[$];

  quartic_sum_hit_verifier_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_x_value        (in_x_value),
    .in_y_value        (in_y_value),
    .in_t_value        (in_t_value),
    .out_valid         (out_valid),
    .out_z_root        (out_z_root),
    .out_hit           (out_hit),
    .out_primitive_res (out_primitive_res),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  quartic_hit_checker #(.N_ADDR(ADDR_N_MULT)) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_x_value        (in_x_value),
    .in_y_value        (in_y_value),
    .in_t_value        (in_t_value),
    .out_valid         (out_valid),
    .out_z_root        (out_z_root),
    .out_hit           (out_hit),
    .out_primitive_res (out_primitive_res),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .pending           (pending),
    .mismatches        (mismatches),
    .results           (results),
    .hits              (hits),
    .primitives        (primitives)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Random value of the given width, biased toward short bit lengths and all ones.
  function automatic logic [31:0] spread(input int w);
    logic [31:0] r;
    int          len;
    r = $urandom();
    if ($urandom_range(0, 19) == 0) return (32'd1 << w) - 1;
    len = ($urandom_range(0, 1) == 0) ? w : $urandom_range(0, w);
    return r & ((32'd1 << len) - 1);
  endfunction

  // One candidate; the start line stays high between back-to-back items.
  task automatic send_candidate(input logic [XW-1:0] x, input logic [XW-1:0] y,
                                input logic [TW-1:0] t, input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && $urandom_range(0, 99) < 12)
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 220) : $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_x_value <= x;
    in_y_value <= y;
    in_t_value <= t;
    do @(posedge clk); while (busy !== 1'b0);
    candidates_sent++;
  endtask

  // Hold off new items until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy !== 1'b0);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [NW-1:0] val);
    logic [CFG_DW-1:0] word;
    word = $urandom();
    word[NW-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // New multiplier; also lists every a^4 + b^4 + c^4 = N with digits up to 3
  // that is a hit at t = 1, so that scaled copies give exact solutions.
  task automatic set_multiplier(input logic [NW-1:0] val);
    drain();
    write_reg(ADDR_N_MULT, val);
    settings_used++;
    triples_q.delete();
    for (int a = 0; a <= 3; a++)
      for (int b = 0; b <= 3; b++)
        for (int c = 0; c <= 3; c++)
          if (a**4 + b**4 + c**4 == int'(val) && b <= c && a + b > 0)
            triples_q.insert(triples_q.size(), quartic_triple_t'{a, b, c});
  endtask

  // Random candidate: exact solutions, slightly broken ones, or free fields.
  task automatic send_random_candidate(input bit may_idle);
    quartic_triple_t tr;
    int              kind;
    int              k;
    logic [XW-1:0]   x;
    logic [XW-1:0]   y;
    logic [TW-1:0]   t;
    kind = $urandom_range(0, 99);
    if (kind < 55 && triples_q.size() > 0) begin
      tr = triples_q[$urandom_range(0, triples_q.size() - 1)];
      case ($urandom_range(0, 3))
        0:       k = 1;
        1:       k = $urandom_range(1, 65535);
        default: k = $urandom_range(2, 300);
      endcase
      x = XW'(tr.a * k);
      y = XW'(tr.b * k);
      t = TW'(k);
      // Broken variants: y in the root's place, or one base off by one bit.
      if (kind >= 40) begin
        case ($urandom_range(0, 2))
          0:       y = XW'(tr.c * k);
          1:       x = x ^ XW'(1);
          default: t = t ^ TW'(1);
        endcase
      end
    end else begin
      x = XW'(spread(XW));
      y = XW'(spread(XW));
      t = TW'(spread(TW));
    end
    send_candidate(x, y, t, may_idle);
  endtask

  initial begin
    candidates_sent = 0;
    settings_used   = 1;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_x_value <= '0;
    in_y_value <= '0;
    in_t_value <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset multiplier of 17 = 0 + 1 + 16.
    send_candidate(0, 0, 1, 1'b0);              // sum zero
    send_candidate(0, 1, 1, 1'b0);              // primitive hit
    send_candidate(1, 0, 1, 1'b0);              // hit with x above y
    send_candidate(0, 2, 1, 1'b0);              // exact but y above z
    send_candidate(0, 5, 5, 1'b0);              // scaled, not primitive
    send_candidate(2, 1, 1, 1'b0);              // sum equals N*t^4
    send_candidate(1, 2, 1, 1'b0);
    send_candidate(0, 1, 0, 1'b0);              // t of zero
    send_candidate(X_MAX, X_MAX, T_MAX, 1'b0);  // sum far above
    send_candidate(0, 0, T_MAX, 1'b0);
    send_candidate(1, 1, T_MAX, 1'b0);          // largest roots
    send_candidate(0, 65535, T_MAX, 1'b0);
    send_candidate(131072, 0, T_MAX, 1'b0);
    send_candidate(0, 131071, T_MAX, 1'b0);
    send_candidate(3, 4, 2, 1'b0);

    // Multipliers of 1, zero and the highest, then a write to an empty address.
    set_multiplier(1);
    send_candidate(1, 0, 1, 1'b0);
    send_candidate(0, 1, 1, 1'b0);
    set_multiplier(0);
    send_candidate(0, 1, 1, 1'b0);
    send_candidate(0, 0, T_MAX, 1'b0);
    set_multiplier(255);
    send_candidate(1, 1, 1, 1'b0);
    send_candidate(X_MAX, 0, T_MAX, 1'b0);
    send_candidate(0, 3, 1, 1'b0);
    drain();
    write_reg(ADDR_SPARE, 5);
    send_candidate(0, 1, 1, 1'b0);

    // Random phases, each under its own multiplier; two phases never idle.
    for (int p = 0; p < PHASES; p++) begin
      if (p % 3 == 0) begin
        drain();
        write_reg(ADDR_SPARE, NW'($urandom()));
      end
      set_multiplier((PHASE_N[p] < 0) ? NW'($urandom_range(0, 255)) : NW'(PHASE_N[p]));
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random_candidate(!(p == 4 || p == 5));
    end

    drain();
    repeat (250) @(posedge clk);
    $display("Sent %0d candidates under %0d multiplier settings, zero, 1 and 255 among them.",
             candidates_sent, settings_used);
    $display("Checked %0d results: %0d exact hits, %0d of them primitive.",
             results, hits, primitives);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/qshv_pkg.sv
sv/quartic_sum_hit_verifier_top.sv
sv/qshv_checker.sv
sim/quartic_hit_checker.sv
sim/testbench.sv
